[src/wildcard_byte_signature_scan_unit_defines.svh]
// Assertion macros used by the top level of the signature scan RTL.
// No dependencies; include it inside a module that has clk_i and rst_ni.
`ifndef WILDCARD_BYTE_SIGNATURE_SCAN_UNIT_DEFINES_SVH
`define WILDCARD_BYTE_SIGNATURE_SCAN_UNIT_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define WBSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wbss assertion failed");

// Condition implies consequence in the next cycle.
`define WBSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wbss assertion failed");

`endif

[src/wbss_pkg.sv]
// Shared types and constants of the wildcard byte signature scanner.
// No dependencies.
`default_nettype none

package wbss_pkg;

  localparam int unsigned MaxPatternDefault = 64;
  localparam logic [7:0]  WildcardByte      = 8'h2A;
  localparam int unsigned AddrW             = 32;
  localparam int unsigned LenRegW           = 7;
  localparam int unsigned IdxW              = 6;
  localparam int unsigned CfgIdxW           = 1;

  localparam logic [CfgIdxW-1:0] CfgPatternLength = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRegionBase    = 1'b1;

  // Per-cycle control that every cell of the row sees.
  typedef struct packed {
    logic scan;    // a memory byte enters the window
    logic clear;   // the byte ends the region, window returns to zero
    logic rotate;  // pattern ring moves one place toward its alignment
  } cell_ctrl_t;

  // One result word.
  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] addr;
  } result_t;

endpackage

`default_nettype wire

[src/wbss_cell.sv]
// One cell of the scan row: a window byte, an aligned pattern byte and the compare.
// Depends on wbss_pkg.
`default_nettype none

module wbss_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wbss_pkg::cell_ctrl_t ctrl_i,
  input  wire logic              load_hit_i,
  input  wire logic [7:0]        data_i,
  input  wire logic [7:0]        win_prev_i,
  input  wire logic [7:0]        pat_next_i,
  input  wire logic              in_use_i,
  output logic [7:0]             win_o,
  output logic [7:0]             pat_o,
  output logic                   hit_o
);

  logic [7:0] win_q, win_d;
  logic [7:0] pat_q, pat_d;

  // The compare sees the window after this cycle's shift.
  assign hit_o = !in_use_i || (pat_q == wbss_pkg::WildcardByte) || (pat_q == win_prev_i);

  always_comb begin
    win_d = win_q;
    if (ctrl_i.scan) begin
      win_d = ctrl_i.clear ? 8'h00 : win_prev_i;
    end
  end

  always_comb begin
    pat_d = pat_q;
    if (ctrl_i.rotate) begin
      pat_d = pat_next_i;
    end else if (load_hit_i) begin
      pat_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 8'h00;
    end else begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
  end

  assign win_o = win_q;
  assign pat_o = pat_q;

endmodule

`default_nettype wire

[src/wbss_out_stage.sv]
// Output register of the scanner; holds one result word until it is taken.
// Depends on wbss_pkg.
`default_nettype none

module wbss_out_stage (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       load_i,
  input  wire wbss_pkg::result_t          res_i,
  input  wire logic                       stall_i,
  output logic                            valid_o,
  output wbss_pkg::result_t               res_o,
  output logic                            busy_o
);

  logic              valid_q, valid_d;
  wbss_pkg::result_t res_q, res_d;

  assign busy_o = valid_q && stall_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

[src/wildcard_byte_signature_scan_unit.sv]
// Top level of the wildcard byte signature scanner.
// Depends on wbss_pkg, wbss_cell, wbss_out_stage and the defines header.
//
// Usage. The input channel carries one word per item: a load word (operation 0)
// writes one signature byte, a scan word (operation 1) shifts one memory byte
// into the window. The output channel returns at most one word per region: found
// with the match address on the first match, or found 0 when the region's last
// byte passes without one. The configuration channel writes the pattern length
// (index 0) and the region base (index 1); it is always ready.
// A result word is registered and appears on the output in the cycle after the
// scan word that caused it. Throughput: one word per cycle while in_stall_o is
// low, set by the row of compare cells that checks every window position in parallel.
// After a change of the pattern length the pattern ring rotates one place per
// cycle into its new alignment, and input stall is held high until it is aligned.
// Reset clears the window, the byte count and the match flag, sets the length to
// 1 and the base to 0; signature bytes are undefined until loaded.
// When the receiver stalls, the result word waits in the output register and a
// new input word is taken only once that register is free or being emptied.
`default_nettype none

module wildcard_byte_signature_scan_unit #(
  parameter int unsigned MAX_PATTERN = wbss_pkg::MaxPatternDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          operation_i,
  input  wire logic [wbss_pkg::IdxW-1:0]     pattern_index_i,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          last_byte_i,
  // Output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               found_o,
  output logic [wbss_pkg::AddrW-1:0]         match_address_o,
  // Configuration channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [wbss_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [wbss_pkg::AddrW-1:0]    cfg_data_i
);

  `include "wildcard_byte_signature_scan_unit_defines.svh"

  localparam int unsigned N  = MAX_PATTERN;
  localparam int unsigned LW = $clog2(N + 1);
  localparam int unsigned PW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CW = LW + 8;  // room for the index and length arithmetic

  // Configuration registers.
  logic [wbss_pkg::LenRegW-1:0] len_q, len_d;
  logic [wbss_pkg::AddrW-1:0]   base_q, base_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    len_d  = len_q;
    base_d = base_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        wbss_pkg::CfgPatternLength: len_d  = cfg_data_i[wbss_pkg::LenRegW-1:0];
        wbss_pkg::CfgRegionBase:    base_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Length in use: zero acts as one, anything above the row length is clamped.
  logic [CW-1:0] len_ext, ulen_ext;
  logic [LW-1:0] ulen;

  assign len_ext = CW'(len_q);

  always_comb begin
    if (len_ext == '0) begin
      ulen_ext = CW'(1);
    end else if (len_ext > CW'(N)) begin
      ulen_ext = CW'(N);
    end else begin
      ulen_ext = len_ext;
    end
  end

  assign ulen = ulen_ext[LW-1:0];

  // The pattern lives in a ring of cells. With rotation offset s, cell q holds
  // signature byte N-1-((q+s) mod N). The ring is aligned when s equals N-len, so
  // that cell q holds the signature byte compared against the byte of age q.
  logic [PW-1:0] rot_q, rot_d;
  logic [CW-1:0] rot_tgt_ext;
  logic          rotate;

  assign rot_tgt_ext = CW'(N) - ulen_ext;
  assign rotate      = (rot_q != rot_tgt_ext[PW-1:0]);

  always_comb begin
    rot_d = rot_q;
    if (rotate) begin
      rot_d = (rot_q == PW'(N - 1)) ? '0 : rot_q + PW'(1);
    end
  end

  // Handshake.
  logic out_busy;
  logic in_acc, scan, load;

  assign in_stall_o = rotate || out_busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign scan       = in_acc && operation_i;
  assign load       = in_acc && !operation_i && (CW'(pattern_index_i) < CW'(N));

  // Ring position that receives a loaded signature byte.
  logic [CW-1:0] ld_t, ld_s, ld_pos;

  assign ld_t = CW'(N - 1) - CW'(pattern_index_i);
  assign ld_s = CW'(rot_q);

  always_comb begin
    if (ld_t >= ld_s) begin
      ld_pos = ld_t - ld_s;
    end else begin
      ld_pos = ld_t + CW'(N) - ld_s;
    end
  end

  // Row of cells.
  wbss_pkg::cell_ctrl_t ctrl;
  logic [7:0]           win  [N];
  logic [7:0]           pat  [N];
  logic [N-1:0]         hit;

  assign ctrl.scan   = scan;
  assign ctrl.clear  = last_byte_i;
  assign ctrl.rotate = rotate;

  for (genvar q = 0; q < N; q++) begin : g_cell
    logic [7:0] win_prev;
    logic       load_hit;
    logic       in_use;

    if (q == 0) begin : g_head
      assign win_prev = data_byte_i;
    end else begin : g_body
      assign win_prev = win[q-1];
    end

    assign load_hit = load && (ld_pos[PW-1:0] == PW'(q));
    assign in_use   = (LW'(q) < ulen);

    wbss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .load_hit_i (load_hit),
      .data_i     (data_byte_i),
      .win_prev_i (win_prev),
      .pat_next_i (pat[(q + 1) % N]),
      .in_use_i   (in_use),
      .win_o      (win[q]),
      .pat_o      (pat[q]),
      .hit_o      (hit[q])
    );
  end

  // Region bookkeeping.
  logic [wbss_pkg::AddrW-1:0] seen_q, seen_d, seen_inc;
  logic                       done_q, done_d;
  logic                       match;
  logic                       res_valid;
  wbss_pkg::result_t          res;

  assign seen_inc  = (&seen_q) ? seen_q : seen_q + wbss_pkg::AddrW'(1);
  assign match     = scan && !done_q && (seen_inc >= wbss_pkg::AddrW'(ulen)) && (&hit);
  assign res_valid = scan && !done_q && (match || last_byte_i);

  assign res.found = match;
  assign res.addr  = match ? (base_q + seen_inc - wbss_pkg::AddrW'(ulen))
                           : '0;

  always_comb begin
    seen_d = seen_q;
    done_d = done_q;
    if (scan) begin
      if (last_byte_i) begin
        seen_d = '0;
        done_d = 1'b0;
      end else begin
        seen_d = seen_inc;
        done_d = done_q || match;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= wbss_pkg::LenRegW'(1);
      base_q <= '0;
      rot_q  <= PW'(N - 1);
      seen_q <= '0;
      done_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      base_q <= base_d;
      rot_q  <= rot_d;
      seen_q <= seen_d;
      done_q <= done_d;
    end
  end

  // Output register.
  wbss_pkg::result_t out_res;

  wbss_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .res_o   (out_res),
    .busy_o  (out_busy)
  );

  assign found_o         = out_res.found;
  assign match_address_o = out_res.addr;

  // No word may be taken while the pattern ring is still moving.
  `WBSS_ASSERT_IMPL(a_rotate_stalls, rotate, in_stall_o)
  // A not-found word only comes from the last byte of a region.
  `WBSS_ASSERT_IMPL(a_miss_on_last, res_valid && !res.found, scan && last_byte_i)
  // A match inside a region silences the rest of that region.
  `WBSS_ASSERT_NEXT(a_match_sets_done, match && !last_byte_i, done_q)
  // The rotation offset stays inside the ring.
  `WBSS_ASSERT_IMPL(a_rot_range, 1'b1, rot_q <= PW'(N - 1))

endmodule

`default_nettype wire

[bench/wbss_scan_checker.sv]
// Result checker for the wildcard byte signature scanner: mirrors the scan state,
// predicts each result word and compares it with the block's output channel.
// Depends on wbss_pkg; also holds the small package of bench-side opcodes.
`timescale 1ns / 1ps

package wbss_tb_pkg;

  typedef enum logic {
    OpLoad = 1'b0,
    OpScan = 1'b1
  } scan_op_e;

endpackage

module wbss_scan_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          operation_i,
  input  logic [wbss_pkg::IdxW-1:0]     pattern_index_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          found_i,
  input  logic [wbss_pkg::AddrW-1:0]    match_address_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [wbss_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wbss_pkg::AddrW-1:0]    cfg_data_i,
  output int unsigned                   outstanding_o,
  output int unsigned                   mismatches_o
);
  import wbss_pkg::*;
  import wbss_tb_pkg::*;

  localparam int unsigned Depth = MaxPatternDefault;

  logic [7:0]         sig_q    [Depth];
  logic [7:0]         window_q [Depth];
  logic [31:0]        seen_q;
  logic               match_done_q;
  logic [LenRegW-1:0] len_reg_q;
  logic [AddrW-1:0]   base_q;
  result_t            pending_q [$];
  int unsigned        mismatch_cnt;

  // A length of zero behaves as one, anything above the store depth as the full depth.
  function automatic int unsigned active_length();
    if (len_reg_q == '0) return 1;
    if (len_reg_q > Depth) return Depth;
    return len_reg_q;
  endfunction

  function automatic logic window_hit(int unsigned len);
    for (int unsigned j = 0; j < len; j++)
      if (sig_q[j] != WildcardByte && sig_q[j] != window_q[len - 1 - j]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input bit have_exp, input result_t exp_r);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      if (have_exp)
        $display("mismatch at %0t: expected found=%0b addr=%08h, got found=%0b addr=%08h",
                 $time, exp_r.found, exp_r.addr, found_i, match_address_i);
      else
        $display("mismatch at %0t: no result expected, got found=%0b addr=%08h",
                 $time, found_i, match_address_i);
    end
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    int unsigned len;
    result_t     r;
    for (int k = Depth - 1; k > 0; k--) window_q[k] = window_q[k - 1];
    window_q[0] = b;
    if (seen_q != 32'hFFFF_FFFF) seen_q++;
    if (!match_done_q) begin
      len = active_length();
      if (seen_q >= len && window_hit(len)) begin
        match_done_q = 1'b1;
        r.found = 1'b1;
        r.addr  = base_q + (seen_q - 32'(len));
        pending_q.push_back(r);
      end else if (last) begin
        r.found = 1'b0;
        r.addr  = '0;
        pending_q.push_back(r);
      end
    end
    if (last) begin
      foreach (window_q[k]) window_q[k] = '0;
      seen_q       = '0;
      match_done_q = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t exp_r;
    if (!rst_ni) begin
      foreach (sig_q[k]) sig_q[k] = '0;
      foreach (window_q[k]) window_q[k] = '0;
      seen_q       = '0;
      match_done_q = 1'b0;
      len_reg_q    = LenRegW'(1);
      base_q       = '0;
      pending_q.delete();
      mismatch_cnt = 0;
    end else begin
      // Results are retired before new ones are predicted in the same cycle.
      if (out_valid_i && !out_stall_i) begin
        if (pending_q.size() == 0) begin
          exp_r = '0;
          note_mismatch(1'b0, exp_r);
        end else begin
          exp_r = pending_q.pop_front();
          if (found_i !== exp_r.found || match_address_i !== exp_r.addr)
            note_mismatch(1'b1, exp_r);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgPatternLength) len_reg_q = cfg_data_i[LenRegW-1:0];
        else if (cfg_index_i == CfgRegionBase) base_q = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        if (operation_i == OpLoad) sig_q[pattern_index_i] = data_byte_i;
        else scan_byte(data_byte_i, last_byte_i);
      end
    end
    outstanding_o <= pending_q.size();
    mismatches_o  <= mismatch_cnt;
  end

endmodule

[bench/wildcard_byte_signature_scan_unit_tb.sv]
// Top of the signature scanner bench: clock, reset, stimulus and the verdict.
// Depends on wbss_pkg, wbss_tb_pkg and wbss_scan_checker, which does all checking.
`timescale 1ns / 1ps

module wildcard_byte_signature_scan_unit_tb;
  import wbss_pkg::*;
  import wbss_tb_pkg::*;

  localparam int unsigned Depth      = MaxPatternDefault;
  localparam int unsigned WordTarget = 1600;
  // Words sent after this point go out with no idling on either side.
  localparam int unsigned CalmAfter  = 1400;
  localparam int unsigned CycleLimit = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               operation = 1'b0;
  logic [IdxW-1:0]    pattern_index = '0;
  logic [7:0]         data_byte = '0;
  logic               last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               found;
  logic [AddrW-1:0]   match_address;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [AddrW-1:0]   cfg_data = '0;

  int unsigned outstanding;
  int unsigned mismatches;

  // Bench-side view of the signature, used only to shape the stimulus so that
  // regions actually contain matches. The checker keeps its own copy.
  logic [7:0]  sig_bytes  [Depth];
  bit          sig_loaded [Depth];
  int unsigned active_len = 1;
  int unsigned words_sent = 0;
  bit          idle_en = 1'b1;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  always #10 clk_i = ~clk_i;

  wildcard_byte_signature_scan_unit #(
    .MAX_PATTERN(Depth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .operation_i    (operation),
    .pattern_index_i(pattern_index),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .found_o        (found),
    .match_address_o(match_address),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  wbss_scan_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .operation_i    (operation),
    .pattern_index_i(pattern_index),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .found_i        (found),
    .match_address_i(match_address),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .outstanding_o  (outstanding),
    .mismatches_o   (mismatches)
  );

  // Receiver side: stalls come in bursts, at a rate that the current phase picks,
  // and stop entirely for the calm tail of the run.
  initial begin : receiver
    int unsigned burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (idle_en && burst == 0 && $urandom_range(0, 99) < stall_pct)
        burst = $urandom_range(1, 5);
      if (burst != 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  initial begin : watchdog
    int unsigned cycles_run;
    cycles_run = 0;
    while (cycles_run < CycleLimit) begin
      @(posedge clk_i);
      cycles_run++;
    end
    $display("** wildcard_byte_signature_scan_unit: FAILED **");
    $finish;
  end

  // Presents one word and returns at the edge that accepts it. Valid stays high
  // afterwards so back-to-back words need no extra assignment in the same step;
  // only a sender gap or an idle wait lowers it.
  task automatic send_word(input scan_op_e op, input logic [IdxW-1:0] idx,
                           input logic [7:0] b, input logic last);
    if (idle_en && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    pattern_index <= idx;
    data_byte     <= b;
    last_byte     <= last;
    do @(posedge clk_i); while (in_stall);
    words_sent++;
    if (words_sent >= CalmAfter) idle_en = 1'b0;
  endtask

  // Load words ignore last_byte, so it is driven at random to prove that.
  task automatic load_sig(input logic [IdxW-1:0] idx, input logic [7:0] b);
    sig_bytes[idx]  = b;
    sig_loaded[idx] = 1'b1;
    send_word(OpLoad, idx, b, 1'($urandom_range(0, 1)));
  endtask

  task automatic scan(input logic [7:0] b, input logic last);
    send_word(OpScan, IdxW'($urandom_range(0, Depth - 1)), b, last);
  endtask

  // Stops sending and waits until every predicted result word has drained,
  // then waits on for a load or a region tail still inside the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle. Both writes share one
  // valid pulse so valid is never lowered and raised in the same step.
  task automatic set_registers(input bit wr_len, input logic [LenRegW-1:0] len,
                               input bit wr_base, input logic [AddrW-1:0] base);
    cfg_valid <= 1'b1;
    if (wr_len) begin
      cfg_index <= CfgPatternLength;
      cfg_data  <= AddrW'(len);
      do @(posedge clk_i); while (!cfg_ready);
      active_len = (len == 0) ? 1 : (len > Depth) ? Depth : len;
    end
    if (wr_base) begin
      cfg_index <= CfgRegionBase;
      cfg_data  <= base;
      do @(posedge clk_i); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_sig_byte();
    return ($urandom_range(0, 3) == 0) ? WildcardByte : 8'($urandom_range(0, 255));
  endfunction

  // Every signature byte the compare can reach must have been written first,
  // since the store holds garbage until then.
  task automatic fill_signature();
    for (int unsigned i = 0; i < active_len; i++)
      if (!sig_loaded[i]) load_sig(IdxW'(i), pick_sig_byte());
  endtask

  // Filler bytes are biased toward signature bytes, the wildcard value and the
  // extremes so that partial matches and false starts show up often.
  function automatic logic [7:0] filler_byte();
    case ($urandom_range(0, 4))
      0:       return sig_bytes[$urandom_range(0, active_len - 1)];
      1:       return WildcardByte;
      2:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One region: most plant a copy of the signature (wildcards replaced by
  // random bytes) after a random lead-in; some are shorter than the signature
  // and must end with found cleared. Now and then a signature byte is
  // rewritten in the middle of the region.
  task automatic scan_region();
    int unsigned lead;
    int unsigned total;
    bit          plant;
    bit          short_run;
    logic [7:0]  b;
    fill_signature();
    plant     = $urandom_range(0, 99) < 70;
    short_run = active_len > 1 && $urandom_range(0, 99) < 10;
    lead      = $urandom_range(0, 12);
    total     = short_run ? $urandom_range(1, active_len - 1)
                          : lead + active_len + $urandom_range(0, 6);
    for (int unsigned k = 0; k < total; k++) begin
      if ($urandom_range(0, 99) < 4) load_sig(IdxW'($urandom_range(0, Depth - 1)),
                                              pick_sig_byte());
      if (plant && !short_run && k >= lead && k < lead + active_len &&
          sig_bytes[k - lead] != WildcardByte)
        b = sig_bytes[k - lead];
      else
        b = filler_byte();
      scan(b, k == total - 1);
    end
  endtask

  initial begin : stimulus
    logic [LenRegW-1:0] len;
    logic [AddrW-1:0]   base;
    int unsigned        regions;

    foreach (sig_loaded[i]) sig_loaded[i] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Reset leaves a one-byte signature and base zero. A match
    // on the region's last byte gives exactly one word, and the load's
    // last_byte is set to show it is ignored.
    sig_bytes[0]  = 8'h00;
    sig_loaded[0] = 1'b1;
    send_word(OpLoad, '0, 8'h00, 1'b1);
    scan(8'hFF, 1'b0);
    scan(8'h00, 1'b1);

    // Three-byte signature 00 2A FF with the base at the top of the address
    // space, so a match one byte in wraps to address zero. The top index is
    // loaded too, though it is outside the signature in use.
    wait_idle();
    set_registers(1'b1, LenRegW'(3), 1'b1, 32'hFFFF_FFFF);
    load_sig(IdxW'(1), WildcardByte);
    load_sig(IdxW'(2), 8'hFF);
    load_sig(IdxW'(Depth - 1), 8'hFF);
    // A region shorter than the signature ends without a match.
    scan(8'h00, 1'b1);
    // The signature sits at offset one; bytes after the match give nothing.
    scan(8'h11, 1'b0);
    scan(8'h00, 1'b0);
    scan(8'h7E, 1'b0);
    scan(8'hFF, 1'b0);
    scan(8'h00, 1'b1);

    // The base changes in the middle of a region and applies from the next byte.
    scan(8'h00, 1'b0);
    wait_idle();
    set_registers(1'b0, '0, 1'b1, 32'h0000_1000);
    scan(8'h5A, 1'b0);
    scan(8'hFF, 1'b1);

    // A length of zero behaves as one; an all-wildcard signature matches the
    // first byte, and a memory byte equal to the wildcard value is plain data.
    wait_idle();
    set_registers(1'b1, '0, 1'b0, '0);
    load_sig('0, WildcardByte);
    scan(8'hAB, 1'b0);
    scan(WildcardByte, 1'b1);
    load_sig('0, 8'h2B);
    scan(WildcardByte, 1'b0);
    scan(8'h2B, 1'b1);

    // Random part, in phases. Each phase starts from an idle block, which is
    // also where the sender holds off until every result word has come back.
    while (words_sent < WordTarget) begin
      wait_idle();
      case ($urandom_range(0, 11))
        0:       len = '0;
        1:       len = LenRegW'(1);
        2:       len = LenRegW'(Depth);
        3:       len = LenRegW'($urandom_range(Depth + 1, 127));
        4:       len = '1;
        5:       len = LenRegW'($urandom_range(9, Depth - 1));
        default: len = LenRegW'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 3))
        0:       base = '0;
        1:       base = '1;
        2:       base = 32'hFFFF_FFFF - $urandom_range(0, 31);
        default: base = $urandom;
      endcase
      set_registers(1'b1, len, $urandom_range(0, 2) != 0, base);
      gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      // Refresh a few signature bytes so the pattern content keeps changing.
      repeat ($urandom_range(0, 4))
        load_sig(IdxW'($urandom_range(0, active_len - 1)), pick_sig_byte());
      regions = $urandom_range(2, 6);
      for (int unsigned r = 0; r < regions && words_sent < WordTarget; r++)
        scan_region();
    end

    // Drain: all results out, then a short settle for anything stray.
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** wildcard_byte_signature_scan_unit: PASSED **");
    end else begin
      $display("** wildcard_byte_signature_scan_unit: FAILED **");
    end
    $finish;
  end

endmodule
